[sv/sppc_pkg.sv]
package sppc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_ARM_DOWN   = 4'd1,
    PH_GRAB0      = 4'd2,
    PH_GRAB270    = 4'd3,
    PH_NUDGE_BACK = 4'd4,
    PH_ARM_UP     = 4'd5,
    PH_RELEASE    = 4'd6,
    PH_NUDGE_FWD  = 4'd7,
    PH_TRAVEL     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_BACK        = 3'd0,
    CMD_FWD         = 3'd1,
    CMD_DONE_FIRST  = 3'd2,
    CMD_DONE_SECOND = 3'd3,
    CMD_DONE_OTHER  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_START_KIND = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_SLEW_STEP     = 3'd0,
    CFG_RAMP_PERIOD   = 3'd1,
    CFG_ARM_SETTLE    = 3'd2,
    CFG_GRAB_SETTLE   = 3'd3,
    CFG_RELEASE_SETTLE = 3'd4,
    CFG_NUDGE         = 3'd5,
    CFG_BALL_TARGET   = 3'd6,
    CFG_PWM_PERIOD    = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;

  localparam logic [15:0] ROT_OPEN_US   = 16'd900;
  localparam logic [15:0] ROT_GRAB_US   = 16'd2100;
  localparam logic [15:0] RACK_OPEN_US  = 16'd1900;
  localparam logic [15:0] RACK_CLOSE_US = 16'd1100;
  localparam logic [15:0] ARM_DOWN_US   = 16'd2300;
  localparam logic [15:0] ARM_UP_US     = 16'd1100;
  localparam logic [15:0] ARM_TRAVEL_US = 16'd1500;

  localparam logic [3:0] BALL_MAX = 4'd15;

  typedef struct packed {
    logic [7:0]  slew_step_us;
    logic [7:0]  ramp_period_ms;
    logic [15:0] arm_settle_ms;
    logic [15:0] grab_settle_ms;
    logic [15:0] release_settle_ms;
    logic [15:0] nudge_ms;
    logic [3:0]  ball_target;
    logic [15:0] pwm_period_ticks;
  } cfg_t;

  // Servo order in the width arrays: 0 rotation, 1 rack, 2 arm.
  typedef struct packed {
    logic [2:0][15:0] width_us;
    logic             cmd_valid;
    logic [2:0]       cmd_code;
    logic             busy;
    logic [3:0]       balls_done;
  } seq_res_t;

endpackage

[sv/sppc_cfg.sv]
module sppc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output sppc_pkg::cfg_t     cfg
);

  sppc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slew_step_us      <= 8'd5;
      cfg_r.ramp_period_ms    <= 8'd10;
      cfg_r.arm_settle_ms     <= 16'd150;
      cfg_r.grab_settle_ms    <= 16'd150;
      cfg_r.release_settle_ms <= 16'd150;
      cfg_r.nudge_ms          <= 16'd300;
      cfg_r.ball_target       <= 4'd6;
      cfg_r.pwm_period_ticks  <= 16'd16665;
    end else if (cfg_valid) begin
      unique case (sppc_pkg::cfg_idx_t'(cfg_index))
        sppc_pkg::CFG_SLEW_STEP:      cfg_r.slew_step_us      <= cfg_data[7:0];
        sppc_pkg::CFG_RAMP_PERIOD:    cfg_r.ramp_period_ms    <= cfg_data[7:0];
        sppc_pkg::CFG_ARM_SETTLE:     cfg_r.arm_settle_ms     <= cfg_data;
        sppc_pkg::CFG_GRAB_SETTLE:    cfg_r.grab_settle_ms    <= cfg_data;
        sppc_pkg::CFG_RELEASE_SETTLE: cfg_r.release_settle_ms <= cfg_data;
        sppc_pkg::CFG_NUDGE:          cfg_r.nudge_ms          <= cfg_data;
        sppc_pkg::CFG_BALL_TARGET:    cfg_r.ball_target       <= cfg_data[3:0];
        sppc_pkg::CFG_PWM_PERIOD:     cfg_r.pwm_period_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/sppc_seq.sv]
module sppc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_valid,
  input  logic [1:0]           step_op,
  input  logic [1:0]           step_kind,
  input  sppc_pkg::cfg_t       cfg,
  output sppc_pkg::seq_res_t   res
);

  sppc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       ball_r, ball_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [15:0]      settle_r, settle_nxt;
  logic [7:0]       ramp_cnt_r, ramp_cnt_nxt;
  logic             ramp_act_r, ramp_act_nxt;
  logic [2:0][15:0] cur_r, cur_nxt;
  logic [2:0][15:0] tgt_r, tgt_nxt;

  logic [2:0][15:0] stepped;
  logic             all_arrived;
  logic             busy_now;
  logic             do_enter;
  sppc_pkg::phase_t ent_ph;
  logic             cmd_v;
  sppc_pkg::cmd_t   cmd_c;

  function automatic logic [15:0] step_toward(input logic [15:0] cur,
                                              input logic [15:0] tgt,
                                              input logic [7:0]  slew);
    logic [16:0] up;
    logic [15:0] dn;
    logic [15:0] r;
    up = {1'b0, cur} + {9'b0, slew};
    dn = (cur > {8'b0, slew}) ? (cur - {8'b0, slew}) : 16'd0;
    if (cur < tgt) begin
      r = (up > {1'b0, tgt}) ? tgt : up[15:0];
    end else if (cur > tgt) begin
      r = (dn < tgt) ? tgt : dn;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  assign busy_now = (phase_r != sppc_pkg::PH_IDLE);

  always_comb begin
    all_arrived = 1'b1;
    for (int i = 0; i < 3; i++) begin
      stepped[i] = step_toward(cur_r[i], tgt_r[i], cfg.slew_step_us);
      if (stepped[i] != tgt_r[i]) all_arrived = 1'b0;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    ball_nxt     = ball_r;
    kind_nxt     = kind_r;
    settle_nxt   = settle_r;
    ramp_cnt_nxt = ramp_cnt_r;
    ramp_act_nxt = ramp_act_r;
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    do_enter     = 1'b0;
    ent_ph       = sppc_pkg::PH_ARM_DOWN;
    cmd_v        = 1'b0;
    cmd_c        = sppc_pkg::CMD_BACK;

    if (step_valid) begin
      if (sppc_pkg::op_t'(step_op) == sppc_pkg::OP_TICK) begin
        // The ramp runs first; a phase change below may rearm it.
        if (ramp_act_r) begin
          if (ramp_cnt_r <= 8'd1) begin
            cur_nxt = stepped;
            if (all_arrived) begin
              ramp_act_nxt = 1'b0;
              ramp_cnt_nxt = 8'd0;
            end else begin
              ramp_cnt_nxt = cfg.ramp_period_ms;
            end
          end else begin
            ramp_cnt_nxt = ramp_cnt_r - 8'd1;
          end
        end
        if (busy_now) begin
          if (settle_r <= 16'd1) begin
            settle_nxt = 16'd0;
            if (phase_r == sppc_pkg::PH_TRAVEL) begin
              ball_nxt = (ball_r < sppc_pkg::BALL_MAX) ? ball_r + 4'd1 : ball_r;
              if (ball_nxt < cfg.ball_target) begin
                do_enter = 1'b1;
                ent_ph   = sppc_pkg::PH_ARM_DOWN;
              end else begin
                // Run complete: park the servos in the safe pose.
                tgt_nxt[0]   = sppc_pkg::ROT_OPEN_US;
                tgt_nxt[1]   = sppc_pkg::RACK_OPEN_US;
                tgt_nxt[2]   = sppc_pkg::ARM_TRAVEL_US;
                ramp_act_nxt = 1'b1;
                ramp_cnt_nxt = cfg.ramp_period_ms;
                cmd_v        = 1'b1;
                if (kind_r == sppc_pkg::KIND_SECOND) begin
                  cmd_c = sppc_pkg::CMD_DONE_SECOND;
                end else if (kind_r == sppc_pkg::KIND_OTHER) begin
                  cmd_c = sppc_pkg::CMD_DONE_OTHER;
                end else begin
                  cmd_c = sppc_pkg::CMD_DONE_FIRST;
                end
                phase_nxt  = sppc_pkg::PH_IDLE;
                settle_nxt = 16'd0;
              end
            end else begin
              do_enter = 1'b1;
              ent_ph   = sppc_pkg::phase_t'(phase_r + 4'd1);
            end
          end else begin
            settle_nxt = settle_r - 16'd1;
          end
        end
      end else if ((sppc_pkg::op_t'(step_op) == sppc_pkg::OP_START ||
                    sppc_pkg::op_t'(step_op) == sppc_pkg::OP_START_KIND) && !busy_now) begin
        kind_nxt = (sppc_pkg::op_t'(step_op) == sppc_pkg::OP_START_KIND) ? step_kind : 2'd0;
        ball_nxt = 4'd0;
        do_enter = 1'b1;
        ent_ph   = sppc_pkg::PH_ARM_DOWN;
      end
    end

    if (do_enter) begin
      phase_nxt = ent_ph;
      unique case (ent_ph)
        sppc_pkg::PH_ARM_DOWN: begin
          tgt_nxt[1] = sppc_pkg::RACK_OPEN_US;
          tgt_nxt[2] = sppc_pkg::ARM_DOWN_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.arm_settle_ms;
        end
        sppc_pkg::PH_GRAB0: begin
          tgt_nxt[0] = sppc_pkg::ROT_OPEN_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.grab_settle_ms;
        end
        sppc_pkg::PH_GRAB270: begin
          tgt_nxt[0] = sppc_pkg::ROT_GRAB_US;
          tgt_nxt[1] = sppc_pkg::RACK_CLOSE_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.grab_settle_ms;
        end
        sppc_pkg::PH_NUDGE_BACK: begin
          cmd_v      = 1'b1;
          cmd_c      = sppc_pkg::CMD_BACK;
          settle_nxt = cfg.nudge_ms;
        end
        sppc_pkg::PH_ARM_UP: begin
          tgt_nxt[2] = sppc_pkg::ARM_UP_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.arm_settle_ms;
        end
        sppc_pkg::PH_RELEASE: begin
          tgt_nxt[0] = sppc_pkg::ROT_OPEN_US;
          tgt_nxt[1] = sppc_pkg::RACK_OPEN_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.release_settle_ms;
        end
        sppc_pkg::PH_NUDGE_FWD: begin
          cmd_v      = 1'b1;
          cmd_c      = sppc_pkg::CMD_FWD;
          settle_nxt = cfg.nudge_ms;
        end
        sppc_pkg::PH_TRAVEL: begin
          tgt_nxt[2] = sppc_pkg::ARM_TRAVEL_US;
          ramp_act_nxt = 1'b1;
          ramp_cnt_nxt = cfg.ramp_period_ms;
          settle_nxt   = cfg.arm_settle_ms;
        end
        default: begin
          phase_nxt  = sppc_pkg::PH_IDLE;
          settle_nxt = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sppc_pkg::PH_IDLE;
      ball_r     <= 4'd0;
      kind_r     <= 2'd0;
      settle_r   <= 16'd0;
      ramp_cnt_r <= 8'd0;
      ramp_act_r <= 1'b0;
      cur_r[0]   <= sppc_pkg::ROT_OPEN_US;
      cur_r[1]   <= sppc_pkg::RACK_OPEN_US;
      cur_r[2]   <= sppc_pkg::ARM_TRAVEL_US;
      tgt_r[0]   <= sppc_pkg::ROT_OPEN_US;
      tgt_r[1]   <= sppc_pkg::RACK_OPEN_US;
      tgt_r[2]   <= sppc_pkg::ARM_TRAVEL_US;
    end else begin
      phase_r    <= phase_nxt;
      ball_r     <= ball_nxt;
      kind_r     <= kind_nxt;
      settle_r   <= settle_nxt;
      ramp_cnt_r <= ramp_cnt_nxt;
      ramp_act_r <= ramp_act_nxt;
      cur_r      <= cur_nxt;
      tgt_r      <= tgt_nxt;
    end
  end

  assign res.width_us   = cur_nxt;
  assign res.cmd_valid  = cmd_v;
  assign res.cmd_code   = cmd_v ? cmd_c : 3'd0;
  assign res.busy       = (phase_nxt != sppc_pkg::PH_IDLE);
  assign res.balls_done = ball_nxt;

endmodule

[sv/servo_pick_place_sequencer.sv]
// Pick-and-place sequencer for a grabber rotation servo, a rack servo and an
// arm servo. Each transaction on the in_ channel is one event: a millisecond
// tick (in_tuser 0) or a start request (in_tuser 1, or 2 with the run kind in
// in_tdata). Every event yields exactly one transaction on the out_ channel
// with the three compare values, any command issued, the busy flag and the
// ball count. The user must write registers over the cfg_ channel only
// while idle; the block itself does not enforce it. An event passes the
// input register, then the step logic into the result register behind
// out_tvalid. Events pass at one per cycle while results are taken; the
// state update and the clamped us-to-ticks conversion are combinational.
// Reset clears the sequence to idle with the servos in the travel pose and
// loads the register defaults; no clearing pass is needed.
// When the receiver stalls, the result register holds and the input
// register still takes one more event; in_tready falls after that and the
// state does not advance until the result is taken.
module servo_pick_place_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] collect_kind
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] rotate_compare, [31:16] rack_compare, [47:32] arm_compare,
  // [48] cmd_valid, [51:49] cmd_code, [52] busy_res, [56:53] balls_done
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sppc_pkg::cfg_t     cfg;
  sppc_pkg::seq_res_t res;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [1:0]  s1_kind_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_can;
  logic        s1_move;
  logic [15:0] ticks [3];

  function automatic logic [15:0] to_ticks(input logic [15:0] us,
                                           input logic [15:0] period);
    logic [18:0] x5;
    logic [17:0] t;
    // us * 25 / 10 equals floor(us * 5 / 2).
    x5 = {1'b0, us, 2'b00} + {3'b000, us};
    t  = x5[18:1];
    return (t > {2'b00, period}) ? period : t[15:0];
  endfunction

  sppc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_can   = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_can;
  assign in_tready = !s1_valid_r || out_can;

  sppc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (s1_move),
    .step_op    (s1_op_r),
    .step_kind  (s1_kind_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ticks[i] = to_ticks(res.width_us[i], cfg.pwm_period_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_can) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_kind_r <= in_tdata[1:0];
    end
    if (s1_move) begin
      out_data_r <= {7'd0, res.balls_done, res.busy, res.cmd_code, res.cmd_valid,
                     ticks[2], ticks[1], ticks[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/sppc_checker.sv]
module sppc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // A result that waits keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // With the result register empty there is always room for an event.
  a_ready_empty: assert property (@(posedge clk)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output empty");

  // An event taken with the output empty goes on to set out_tvalid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing two cycles after acceptance");

  // The command code field is zero when no command is issued.
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[48] |-> out_tdata[51:49] == 3'd0)
    else $error("command code without command");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind servo_pick_place_sequencer sppc_checker u_sppc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sppc_pkg::*;

  localparam int RANDOM_SETTINGS   = 9;
  localparam int ITEMS_PER_SETTING = 135;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES      = 20;

  localparam logic [1:0] KIND_FIRST    = 2'd0;
  localparam logic [1:0] KIND_AS_FIRST = 2'd3;

  // Result fields as they sit in out_tdata, highest field first.
  typedef struct packed {
    logic [3:0]  balls;
    logic        busy;
    logic [2:0]  code;
    logic        valid;
    logic [15:0] arm;
    logic [15:0] rack;
    logic [15:0] rot;
  } servo_result_t;

  class pick_place_scoreboard;
    cfg_t          regs;
    phase_t        phase;
    logic [3:0]    balls;
    logic [1:0]    run_kind;
    logic [15:0]   settle_left;
    logic [7:0]    ramp_left;
    logic          ramp_on;
    logic [15:0]   cur_us [3];
    logic [15:0]   tgt_us [3];
    logic          cmd_on;
    cmd_t          cmd_code;
    servo_result_t expected_results [$];
    int            errors;

    function new();
      regs.slew_step_us      = 8'd5;
      regs.ramp_period_ms    = 8'd10;
      regs.arm_settle_ms     = 16'd150;
      regs.grab_settle_ms    = 16'd150;
      regs.release_settle_ms = 16'd150;
      regs.nudge_ms          = 16'd300;
      regs.ball_target       = 4'd6;
      regs.pwm_period_ticks  = 16'd16665;
      phase       = PH_IDLE;
      balls       = '0;
      run_kind    = KIND_FIRST;
      settle_left = '0;
      ramp_left   = '0;
      ramp_on     = 1'b0;
      cur_us[0]   = ROT_OPEN_US;
      cur_us[1]   = RACK_OPEN_US;
      cur_us[2]   = ARM_TRAVEL_US;
      tgt_us      = cur_us;
      cmd_on      = 1'b0;
      cmd_code    = CMD_BACK;
      errors      = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        CFG_SLEW_STEP:      regs.slew_step_us      = value[7:0];
        CFG_RAMP_PERIOD:    regs.ramp_period_ms    = value[7:0];
        CFG_ARM_SETTLE:     regs.arm_settle_ms     = value;
        CFG_GRAB_SETTLE:    regs.grab_settle_ms    = value;
        CFG_RELEASE_SETTLE: regs.release_settle_ms = value;
        CFG_NUDGE:          regs.nudge_ms          = value;
        CFG_BALL_TARGET:    regs.ball_target       = value[3:0];
        CFG_PWM_PERIOD:     regs.pwm_period_ticks  = value;
        default: ;
      endcase
    endfunction

    function void set_targets(logic [15:0] rot, logic [15:0] rack, logic [15:0] arm);
      tgt_us[0] = rot;
      tgt_us[1] = rack;
      tgt_us[2] = arm;
      ramp_on   = 1'b1;
      ramp_left = regs.ramp_period_ms;
    endfunction

    function void enter_phase(phase_t next);
      phase = next;
      case (next)
        PH_ARM_DOWN: begin
          set_targets(tgt_us[0], RACK_OPEN_US, ARM_DOWN_US);
          settle_left = regs.arm_settle_ms;
        end
        PH_GRAB0: begin
          set_targets(ROT_OPEN_US, tgt_us[1], tgt_us[2]);
          settle_left = regs.grab_settle_ms;
        end
        PH_GRAB270: begin
          set_targets(ROT_GRAB_US, RACK_CLOSE_US, tgt_us[2]);
          settle_left = regs.grab_settle_ms;
        end
        PH_NUDGE_BACK: begin
          cmd_on      = 1'b1;
          cmd_code    = CMD_BACK;
          settle_left = regs.nudge_ms;
        end
        PH_ARM_UP: begin
          set_targets(tgt_us[0], tgt_us[1], ARM_UP_US);
          settle_left = regs.arm_settle_ms;
        end
        PH_RELEASE: begin
          set_targets(ROT_OPEN_US, RACK_OPEN_US, tgt_us[2]);
          settle_left = regs.release_settle_ms;
        end
        PH_NUDGE_FWD: begin
          cmd_on      = 1'b1;
          cmd_code    = CMD_FWD;
          settle_left = regs.nudge_ms;
        end
        PH_TRAVEL: begin
          set_targets(tgt_us[0], tgt_us[1], ARM_TRAVEL_US);
          settle_left = regs.arm_settle_ms;
        end
        default: begin
          phase       = PH_IDLE;
          settle_left = '0;
        end
      endcase
    endfunction

    // The ramp moves first; the settle countdown of the phase comes second.
    function void advance_tick();
      int          i;
      int unsigned nxt;
      logic        arrived;
      if (ramp_on) begin
        if (ramp_left <= 8'd1) begin
          arrived = 1'b1;
          for (i = 0; i < 3; i++) begin
            nxt = cur_us[i];
            if (cur_us[i] < tgt_us[i]) begin
              nxt = cur_us[i] + regs.slew_step_us;
              if (nxt > tgt_us[i]) nxt = tgt_us[i];
            end else if (cur_us[i] > tgt_us[i]) begin
              nxt = (cur_us[i] > regs.slew_step_us) ? cur_us[i] - regs.slew_step_us : 0;
              if (nxt < tgt_us[i]) nxt = tgt_us[i];
            end
            cur_us[i] = nxt[15:0];
            if (cur_us[i] != tgt_us[i]) arrived = 1'b0;
          end
          if (arrived) begin
            ramp_on   = 1'b0;
            ramp_left = '0;
          end else begin
            ramp_left = regs.ramp_period_ms;
          end
        end else begin
          ramp_left--;
        end
      end
      if (phase != PH_IDLE) begin
        if (settle_left <= 16'd1) begin
          settle_left = '0;
          if (phase != PH_TRAVEL) begin
            enter_phase(phase_t'(phase + 1));
          end else begin
            if (balls < BALL_MAX) balls++;
            if (balls < regs.ball_target) begin
              enter_phase(PH_ARM_DOWN);
            end else begin
              set_targets(ROT_OPEN_US, RACK_OPEN_US, ARM_TRAVEL_US);
              cmd_on = 1'b1;
              if (run_kind == KIND_SECOND) cmd_code = CMD_DONE_SECOND;
              else if (run_kind == KIND_OTHER) cmd_code = CMD_DONE_OTHER;
              else cmd_code = CMD_DONE_FIRST;
              enter_phase(PH_IDLE);
            end
          end
        end else begin
          settle_left--;
        end
      end
    endfunction

    function logic [15:0] to_compare(logic [15:0] us);
      int unsigned t;
      t = us;
      t = t * 25 / 10;
      if (t > regs.pwm_period_ticks) t = regs.pwm_period_ticks;
      return t[15:0];
    endfunction

    function void note_event(op_t op, logic [1:0] kind);
      servo_result_t want;
      cmd_on   = 1'b0;
      cmd_code = CMD_BACK;
      if (op == OP_TICK) begin
        advance_tick();
      end else if ((op == OP_START || op == OP_START_KIND) && phase == PH_IDLE) begin
        run_kind = (op == OP_START_KIND) ? kind : KIND_FIRST;
        balls    = '0;
        enter_phase(PH_ARM_DOWN);
      end
      want.rot   = to_compare(cur_us[0]);
      want.rack  = to_compare(cur_us[1]);
      want.arm   = to_compare(cur_us[2]);
      want.valid = cmd_on;
      want.code  = cmd_on ? cmd_code : CMD_BACK;
      want.busy  = (phase != PH_IDLE);
      want.balls = balls;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [63:0] data);
      servo_result_t want;
      servo_result_t got;
      got = data[56:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("rotate_compare", want.rot, got.rot);
      compare_field("rack_compare", want.rack, got.rack);
      compare_field("arm_compare", want.arm, got.arm);
      compare_field("cmd_valid", want.valid, got.valid);
      compare_field("cmd_code", want.code, got.code);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("balls_done", want.balls, got.balls);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [1:0] collect_kind
  logic [1:0]  in_tuser;    // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [15:0] rotate_compare, [31:16] rack_compare, [47:32] arm_compare,
  // [48] cmd_valid, [51:49] cmd_code, [52] busy_res, [56:53] balls_done
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int in_idle_pct  = 8;
  int out_idle_pct = 58;

  pick_place_scoreboard sb;

  servo_pick_place_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(op_t'(in_tuser), in_tdata[1:0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_event(input op_t op, input logic [1:0] kind);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {6'd0, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_SLEW_STEP, {8'd0, s.slew_step_us});
    write_reg(CFG_RAMP_PERIOD, {8'd0, s.ramp_period_ms});
    write_reg(CFG_ARM_SETTLE, s.arm_settle_ms);
    write_reg(CFG_GRAB_SETTLE, s.grab_settle_ms);
    write_reg(CFG_RELEASE_SETTLE, s.release_settle_ms);
    write_reg(CFG_NUDGE, s.nudge_ms);
    write_reg(CFG_BALL_TARGET, {12'd0, s.ball_target});
    write_reg(CFG_PWM_PERIOD, s.pwm_period_ticks);
  endtask

  initial begin
    cfg_t s;
    op_t  op;
    int   p;
    int   n;
    int   r;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLEW_STEP;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // One tick with the register defaults shows the state right after reset.
    send_event(OP_TICK, KIND_FIRST);
    wait_drain();

    // Fast settings so that a whole one-ball run takes eight ticks.
    s = '0;
    s.slew_step_us      = 8'd255;
    s.ramp_period_ms    = 8'd1;
    s.arm_settle_ms     = 16'd1;
    s.grab_settle_ms    = 16'd1;
    s.release_settle_ms = 16'd1;
    s.nudge_ms          = 16'd1;
    s.ball_target       = 4'd1;
    s.pwm_period_ticks  = 16'hFFFF;
    load_settings(s);
    send_event(OP_NONE, KIND_AS_FIRST);
    send_event(OP_TICK, KIND_FIRST);
    send_event(OP_START_KIND, KIND_AS_FIRST);
    send_event(OP_START, KIND_FIRST);
    repeat (8) send_event(OP_TICK, 2'($urandom_range(0, 3)));
    send_event(OP_START_KIND, KIND_OTHER);
    repeat (8) send_event(OP_TICK, 2'($urandom_range(0, 3)));

    for (p = 0; p < RANDOM_SETTINGS; p++) begin
      case (p / 3)
        0: begin
          in_idle_pct  = 8;
          out_idle_pct = 58;
        end
        1: begin
          in_idle_pct  = 58;
          out_idle_pct = 8;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      wait_drain();
      if (p == 0) begin
        s.slew_step_us      = 8'd1;
        s.ramp_period_ms    = 8'd1;
        s.arm_settle_ms     = 16'd1;
        s.grab_settle_ms    = 16'd1;
        s.release_settle_ms = 16'd1;
        s.nudge_ms          = 16'd1;
        s.ball_target       = 4'd1;
        s.pwm_period_ticks  = 16'd1;
      end else if (p == 1) begin
        // Zero slew freezes the widths; a zero ball target ends a run after one ball.
        s = '0;
      end else if (p == RANDOM_SETTINGS - 1) begin
        // Largest values last: the run never leaves its first settle wait.
        s = '1;
      end else begin
        s.slew_step_us = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 20))
                                                     : 8'($urandom_range(100, 255));
        s.ramp_period_ms    = 8'($urandom_range(0, 3));
        s.arm_settle_ms     = 16'($urandom_range(0, 4));
        s.grab_settle_ms    = 16'($urandom_range(0, 4));
        s.release_settle_ms = 16'($urandom_range(0, 4));
        s.nudge_ms          = 16'($urandom_range(0, 4));
        s.ball_target = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
          0:       s.pwm_period_ticks = 16'hFFFF;
          1:       s.pwm_period_ticks = 16'($urandom);
          default: s.pwm_period_ticks = 16'($urandom_range(2000, 6000));
        endcase
      end
      load_settings(s);
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (p == 4 && n == ITEMS_PER_SETTING / 2) wait_drain();
        r = $urandom_range(0, 99);
        if (r < 86) op = OP_TICK;
        else if (r < 91) op = OP_START;
        else if (r < 96) op = OP_START_KIND;
        else op = OP_NONE;
        send_event(op, 2'($urandom_range(0, 3)));
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
